// ===== rtl/core/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned TicksWidth = 16;
  // wide enough for count + 1 and for every threshold
  localparam int unsigned CmpWidth =
      ((CountWidth + 1) > (ThreshWidth + 1)) ? (CountWidth + 1) : (ThreshWidth + 1);

  localparam int unsigned InDataWidth = 8;
  localparam int unsigned OutDataWidth = 48;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [7:0] BlinkTop = 8'd200;
  localparam logic [7:0] BlinkIdle = 8'd150;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SHORT = 2'd0,
    CFG_LONG  = 2'd1,
    CFG_EXTRA = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_HELD    = 2'd2,
    ST_EXTRA   = 2'd3
  } status_e;

  typedef struct packed {
    logic [ThreshWidth-1:0] short_threshold;
    logic [ThreshWidth-1:0] long_threshold;
    logic [ThreshWidth-1:0] extra_threshold;
  } cfg_t;

  typedef struct packed {
    logic blink_enable;
    logic start_clear;
    logic trigger_clear;
    logic start_level;
    logic trigger_level;
  } item_t;

  typedef struct packed {
    logic [7:0]            blink_phase;
    logic [TicksWidth-1:0] start_ticks;
    logic [TicksWidth-1:0] trigger_ticks;
    status_e               start_status;
    status_e               trigger_status;
  } result_t;

  function automatic logic [CmpWidth-1:0] cnt_ext(input logic [CountWidth-1:0] c);
    cnt_ext = CmpWidth'(c);
  endfunction

  function automatic logic [CmpWidth-1:0] thr_ext(input logic [ThreshWidth-1:0] t);
    thr_ext = CmpWidth'(t);
  endfunction

  function automatic logic [CountWidth-1:0] thr_to_cnt(input logic [ThreshWidth-1:0] t);
    logic [CmpWidth-1:0] w;
    w = CmpWidth'(t);
    thr_to_cnt = w[CountWidth-1:0];
  endfunction

  function automatic logic [TicksWidth-1:0] cnt_to_ticks(input logic [CountWidth-1:0] c);
    logic [CmpWidth-1:0] w;
    w = CmpWidth'(c);
    cnt_to_ticks = w[TicksWidth-1:0];
  endfunction

endpackage

// ===== rtl/core/bpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ThreshWidth-1:0] cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_threshold <= ThreshWidth'(5);
      cfg_q.long_threshold  <= ThreshWidth'(100);
      cfg_q.extra_threshold <= ThreshWidth'(500);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHORT: cfg_q.short_threshold <= cfg_data_i;
        CFG_LONG:  cfg_q.long_threshold  <= cfg_data_i;
        CFG_EXTRA: cfg_q.extra_threshold <= cfg_data_i;
        default:   cfg_q <= cfg_q; // unmapped index: drop
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_core
// Press counters, status and blink state; next values for one tick word.
// ----------------------------------------------------------------------------
module bpc_core import bpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [CountWidth-1:0] trig_cnt_q, trig_cnt_d;
  logic [CountWidth-1:0] start_cnt_q, start_cnt_d;
  status_e               trig_st_q, trig_st_d;
  status_e               start_st_q, start_st_d;
  logic [7:0]            blink_q, blink_d;

  logic [CmpWidth-1:0] trig_nxt, start_nxt;
  logic [CmpWidth-1:0] short_w, long_w, extra_w;
  logic                trig_qual, start_qual;
  status_e             trig_st_pre, start_st_pre;
  logic [7:0]          blink_inc;

  always_comb begin
    short_w   = thr_ext(cfg_i.short_threshold);
    long_w    = thr_ext(cfg_i.long_threshold);
    extra_w   = thr_ext(cfg_i.extra_threshold);
    trig_nxt  = cnt_ext(trig_cnt_q) + CmpWidth'(1);
    start_nxt = cnt_ext(start_cnt_q) + CmpWidth'(1);
    trig_qual  = (cnt_ext(trig_cnt_q) > short_w) && (cnt_ext(trig_cnt_q) < long_w);
    start_qual = (cnt_ext(start_cnt_q) > short_w) && (cnt_ext(start_cnt_q) < long_w);

    // clear requests act on status before the tick
    trig_st_pre  = item_i.trigger_clear ? ST_NONE : trig_st_q;
    start_st_pre = item_i.start_clear ? ST_NONE : start_st_q;

    trig_st_d  = trig_st_pre;
    trig_cnt_d = trig_cnt_q;
    if (item_i.trigger_level) begin
      if (trig_nxt > long_w) begin
        trig_cnt_d = thr_to_cnt(cfg_i.long_threshold);
        trig_st_d  = ST_HELD;
      end else begin
        trig_cnt_d = trig_nxt[CountWidth-1:0];
      end
    end else begin
      if (trig_qual) begin
        trig_st_d = ST_PRESSED;
      end else if (trig_st_pre == ST_HELD) begin
        trig_st_d = ST_NONE;
      end
      trig_cnt_d = '0;
    end

    start_st_d  = start_st_pre;
    start_cnt_d = start_cnt_q;
    if (item_i.start_level) begin
      if (start_nxt > extra_w) begin
        start_cnt_d = thr_to_cnt(cfg_i.extra_threshold);
        start_st_d  = ST_EXTRA;
      end else if (start_nxt > long_w) begin
        start_cnt_d = start_nxt[CountWidth-1:0];
        start_st_d  = ST_HELD;
      end else begin
        start_cnt_d = start_nxt[CountWidth-1:0];
      end
    end else begin
      if (start_qual) begin
        start_st_d = ST_PRESSED;
      end else if (start_st_pre == ST_HELD || start_st_pre == ST_EXTRA) begin
        start_st_d = ST_NONE;
      end
      start_cnt_d = '0;
    end

    blink_inc = blink_q + 8'd1;
    if (item_i.blink_enable) begin
      blink_d = (blink_inc > BlinkTop) ? 8'd0 : blink_inc;
    end else begin
      blink_d = BlinkIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_cnt_q  <= '0;
      start_cnt_q <= '0;
      trig_st_q   <= ST_NONE;
      start_st_q  <= ST_NONE;
      blink_q     <= BlinkIdle;
    end else if (advance_i) begin
      trig_cnt_q  <= trig_cnt_d;
      start_cnt_q <= start_cnt_d;
      trig_st_q   <= trig_st_d;
      start_st_q  <= start_st_d;
      blink_q     <= blink_d;
    end
  end

  assign result_o.trigger_status = trig_st_d;
  assign result_o.start_status   = start_st_d;
  assign result_o.trigger_ticks  = cnt_to_ticks(trig_cnt_d);
  assign result_o.start_ticks    = cnt_to_ticks(start_cnt_d);
  assign result_o.blink_phase    = blink_d;

  a_trig_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_st_q != ST_EXTRA) else $error("trigger status reached extra held");

  a_blink_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q <= BlinkTop) else $error("blink counter beyond its top");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.trigger_level && !item_i.start_level |=>
      trig_cnt_q == '0 && start_cnt_q == '0) else $error("released counter not cleared");

  a_blink_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.blink_enable |=> blink_q == BlinkIdle)
    else $error("disabled blink counter not parked");

endmodule

// ===== rtl/core/button_press_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Short/long press classifier for a trigger and a start button, one tick
// word in, one status word out.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_axis    | in        | one timer tick: button levels, clears, blink enable
//  m_axis    | out       | statuses, press durations, blink phase after tick
//  cfg       | in        | threshold write, no read-back
//
// One word per cycle sustained while m_axis is ready; a taken word passes
// through the input register, then the result register, to m_axis.
// The state update happens as a word moves from the input to the result
// register, so a stalled m_axis holds the state too.
// Reset clears both valids and loads the reset thresholds and state.
// ----------------------------------------------------------------------------
module button_press_classifier_unit import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [0] trigger_level, [1] start_level, [2] trigger_clear, [3] start_clear,
  // [4] blink_enable, [7:5] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [1:0] trigger_status, [3:2] start_status, [19:4] trigger_ticks,
  // [35:20] start_ticks, [43:36] blink_phase, [47:44] zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [ThreshWidth-1:0]  cfg_data_i
);

  cfg_t    cfg;
  result_t result;
  item_t   in_q;
  logic    in_vld_q;
  logic    out_vld_q;
  result_t out_q;
  logic    advance;
  logic    take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  bpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bpc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= s_axis_tdata[$bits(item_t)-1:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataWidth'(out_q);

endmodule

// ===== bench/tb_button_press_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier_unit
// Self-checking bench for the button press classifier. Tick words go in on
// s_axis with random gaps, result words come back on m_axis with random
// stalls. A behavioural copy of the classifier predicts every result word,
// and each field is compared. Directed tests cover clicks, held and extra
// held presses, clears, odd and extreme thresholds, blink wrap and a long
// output stall. Random traffic of press runs follows over several threshold
// settings.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_unit import bpc_pkg::*; ();

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [0] trigger_level, [1] start_level, [2] trigger_clear, [3] start_clear,
  // [4] blink_enable, [7:5] zero
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [1:0] trigger_status, [3:2] start_status, [19:4] trigger_ticks,
  // [35:20] start_ticks, [43:36] blink_phase, [47:44] zero
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [ThreshWidth-1:0]  cfg_data_i = '0;

  button_press_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // classifier copy: thresholds and button state
  logic [ThreshWidth-1:0] short_thr, long_thr, extra_thr;
  logic [CountWidth-1:0]  trig_cnt, start_cnt;
  status_e                trig_st, start_st;
  logic [7:0]             blink_cnt;

  result_t pending_results[$];
  int tx_gap_max = 17;
  int rx_stall_max = 17;
  int rx_hold_cycles = 0;
  int mismatches = 0;

  function automatic void reset_classifier();
    short_thr = 16'd5;
    long_thr  = 16'd100;
    extra_thr = 16'd500;
    trig_cnt  = '0;
    start_cnt = '0;
    trig_st   = ST_NONE;
    start_st  = ST_NONE;
    blink_cnt = BlinkIdle;
  endfunction

  function automatic result_t classify_tick(item_t it);
    logic [CountWidth:0] nxt;
    result_t r;
    if (it.trigger_clear) trig_st = ST_NONE;
    if (it.start_clear) start_st = ST_NONE;

    if (it.trigger_level) begin
      nxt = {1'b0, trig_cnt} + 1'b1;
      if (nxt > {1'b0, long_thr}) begin
        trig_cnt = long_thr;
        trig_st  = ST_HELD;
      end else begin
        trig_cnt = nxt[CountWidth-1:0];
      end
    end else begin
      if (trig_cnt > short_thr && trig_cnt < long_thr) trig_st = ST_PRESSED;
      else if (trig_st == ST_HELD) trig_st = ST_NONE;
      trig_cnt = '0;
    end

    if (it.start_level) begin
      nxt = {1'b0, start_cnt} + 1'b1;
      if (nxt > {1'b0, long_thr} && nxt <= {1'b0, extra_thr}) begin
        start_cnt = nxt[CountWidth-1:0];
        start_st  = ST_HELD;
      end else if (nxt > {1'b0, extra_thr}) begin
        start_cnt = extra_thr;
        start_st  = ST_EXTRA;
      end else begin
        start_cnt = nxt[CountWidth-1:0];
      end
    end else begin
      if (start_cnt > short_thr && start_cnt < long_thr) start_st = ST_PRESSED;
      else if (start_st == ST_HELD || start_st == ST_EXTRA) start_st = ST_NONE;
      start_cnt = '0;
    end

    if (it.blink_enable) begin
      blink_cnt = blink_cnt + 8'd1;
      if (blink_cnt > BlinkTop) blink_cnt = 8'd0;
    end else begin
      blink_cnt = BlinkIdle;
    end

    r.trigger_status = trig_st;
    r.start_status   = start_st;
    r.trigger_ticks  = trig_cnt;
    r.start_ticks    = start_cnt;
    r.blink_phase    = blink_cnt;
    return r;
  endfunction

  function automatic item_t make_item(bit tl, bit sl, bit tc, bit sc, bit be);
    item_t it;
    it.trigger_level = tl;
    it.start_level   = sl;
    it.trigger_clear = tc;
    it.start_clear   = sc;
    it.blink_enable  = be;
    return it;
  endfunction

  // offer one tick word; keep tvalid high across back-to-back words
  task automatic send_tick(item_t it);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataWidth'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(classify_tick(it));
  endtask

  task automatic send_run(bit tl, bit sl, int n);
    repeat (n) send_tick(make_item(tl, sl, 1'b0, 1'b0, 1'b1));
  endtask

  // drop tvalid and wait for every outstanding result word
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_thresholds(int unsigned s, int unsigned l, int unsigned e);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SHORT;
    cfg_data_i <= ThreshWidth'(s);
    @(posedge clk_i);
    short_thr = ThreshWidth'(s);
    cfg_idx_i  <= CFG_LONG;
    cfg_data_i <= ThreshWidth'(l);
    @(posedge clk_i);
    long_thr = ThreshWidth'(l);
    cfg_idx_i  <= CFG_EXTRA;
    cfg_data_i <= ThreshWidth'(e);
    @(posedge clk_i);
    extra_thr = ThreshWidth'(e);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int press_len();
    int cap;
    cap = (long_thr > extra_thr) ? int'(long_thr) : int'(extra_thr);
    cap = cap + 4;
    if (cap > 140) cap = 140;
    return $urandom_range(1, cap);
  endfunction

  // press runs with random lengths, occasional clears, blink runs and noise
  task automatic run_random_items(int n);
    bit trig_lvl, start_lvl, blink_on;
    int trig_left, start_left, blink_left;
    item_t it;
    trig_lvl = 1'b0;
    start_lvl = 1'b0;
    blink_on = 1'b0;
    trig_left = 0;
    start_left = 0;
    blink_left = 0;
    for (int i = 0; i < n; i++) begin
      if (trig_left == 0) begin
        trig_lvl  = !trig_lvl;
        trig_left = trig_lvl ? press_len() : $urandom_range(1, 6);
      end
      if (start_left == 0) begin
        start_lvl  = !start_lvl;
        start_left = start_lvl ? press_len() : $urandom_range(1, 6);
      end
      if (blink_left == 0) begin
        blink_on   = !blink_on;
        blink_left = blink_on ? $urandom_range(1, 120) : $urandom_range(1, 4);
      end
      it = make_item(trig_lvl, start_lvl, $urandom_range(0, 9) == 0,
                     $urandom_range(0, 9) == 0, blink_on);
      if ($urandom_range(0, 9) == 0) it = item_t'($bits(item_t)'($urandom));
      send_tick(it);
      trig_left--;
      start_left--;
      blink_left--;
    end
  endtask

  // ---- tests ----

  task automatic test_reset_defaults();
    send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_item(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_tick(make_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
    send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_trigger_presses();
    set_thresholds(2, 6, 10);
    send_run(1'b1, 1'b0, 4);
    send_run(1'b0, 1'b0, 1);   // click
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 1);   // too short, keep status
    send_tick(make_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_run(1'b1, 1'b0, 7);   // saturate and hold
    send_tick(make_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    send_run(1'b0, 1'b0, 1);
  endtask

  task automatic test_start_presses();
    send_run(1'b0, 1'b1, 11);  // held, then extra held
    send_tick(make_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_run(1'b0, 1'b0, 1);
    send_run(1'b0, 1'b1, 3);
    send_run(1'b0, 1'b0, 1);   // click
    send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
  endtask

  task automatic test_odd_thresholds();
    // short above long, extra below long
    set_thresholds(6, 3, 2);
    send_run(1'b1, 1'b1, 5);
    send_run(1'b0, 1'b0, 1);
    send_run(1'b1, 1'b1, 2);
    send_run(1'b0, 1'b0, 1);
  endtask

  task automatic test_extreme_thresholds();
    set_thresholds(0, 1, 2);
    send_run(1'b1, 1'b1, 4);
    send_run(1'b0, 1'b0, 1);
    set_thresholds(65535, 65535, 65535);
    send_run(1'b1, 1'b1, 3);
    send_run(1'b0, 1'b0, 1);
  endtask

  task automatic test_blink_wrap();
    repeat (55) send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_back_pressure();
    set_thresholds(3, 12, 25);
    rx_hold_cycles = 300;
    tx_gap_max = 0;
    run_random_items(40);
    drain();
    tx_gap_max = 17;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_thresholds(3, 12, 25);
        1: set_thresholds(0, 1, 2);
        2: set_thresholds(10, 8, 4);
        3: set_thresholds(5, 100, 500);
        4: set_thresholds(1, 20, 21);
        default: set_thresholds($urandom_range(0, 15), $urandom_range(1, 30),
                                $urandom_range(2, 60));
      endcase
      tx_gap_max   = (phase % 3 == 2) ? 0 : 17;
      rx_stall_max = (phase % 2 == 1) ? 0 : 17;
      run_random_items(200);
    end
    drain();
  endtask

  // ---- result side ----

  initial begin : accept_results
    int stall;
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid));
    end
  end

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result word %h with none outstanding", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("trigger_status", want.trigger_status, got.trigger_status);
        report_field("start_status", want.start_status, got.start_status);
        report_field("trigger_ticks", want.trigger_ticks, got.trigger_ticks);
        report_field("start_ticks", want.start_ticks, got.start_ticks);
        report_field("blink_phase", want.blink_phase, got.blink_phase);
      end
    end
  end

  // ---- sequence ----

  initial begin
    reset_classifier();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_trigger_presses();
    test_start_presses();
    test_odd_thresholds();
    test_extreme_thresholds();
    test_blink_wrap();
    test_back_pressure();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
